// ===== hw/rtl/rwht_pkg.sv =====
//------------------------------------------------------------------------------
// rwht_pkg
// Types and constants shared by the read/write hazard tracker modules.
//------------------------------------------------------------------------------
`default_nettype none

package rwht_pkg;

  localparam int SLOT_W = 6;
  localparam int MASK_W = 32;
  localparam int DEP_W  = 64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // One table entry: a valid flag and the slot of the task that last touched it.
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
  } entry_t;

  typedef struct packed {
    logic              clear;
    logic              upd;
    logic              wr_hit;
    logic              rd_hit;
    logic [SLOT_W-1:0] slot;
  } tbl_ctrl_t;

  typedef struct packed {
    logic              clr;
    logic              en;
    logic [SLOT_W-1:0] own_slot;
  } dep_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rwht_table.sv =====
//------------------------------------------------------------------------------
// rwht_table
// Last writer and last reader table for one class of shared data, with
// per-entry valid flags that a frame start clears at once.
//------------------------------------------------------------------------------
`default_nettype none

module rwht_table import rwht_pkg::*; #(
  parameter int ENTRIES = 32,
  parameter int IDX_W   = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  tbl_ctrl_t        ctrl,
  input  logic [IDX_W-1:0] idx,
  output entry_t           writer,
  output entry_t           reader
);

  logic [ENTRIES-1:0] wr_vld;
  logic [ENTRIES-1:0] rd_vld;
  logic [SLOT_W-1:0]  wr_slot [ENTRIES];
  logic [SLOT_W-1:0]  rd_slot [ENTRIES];

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      wr_vld <= '0;
      rd_vld <= '0;
    end else if (ctrl.upd) begin
      if (ctrl.wr_hit) begin
        wr_vld[idx] <= 1'b1;
      end
      if (ctrl.rd_hit) begin
        rd_vld[idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.upd && ctrl.wr_hit) begin
      wr_slot[idx] <= ctrl.slot;
    end
    if (ctrl.upd && ctrl.rd_hit) begin
      rd_slot[idx] <= ctrl.slot;
    end
  end

  assign writer.valid = wr_vld[idx];
  assign writer.slot  = wr_slot[idx];
  assign reader.valid = rd_vld[idx];
  assign reader.slot  = rd_slot[idx];

endmodule

`default_nettype wire

// ===== hw/rtl/rwht_dep_unit.sv =====
//------------------------------------------------------------------------------
// rwht_dep_unit
// Shared dependency unit: turns the entries read at the current index into
// slot bits and gathers them in the dependency accumulator.
//------------------------------------------------------------------------------
`default_nettype none

module rwht_dep_unit import rwht_pkg::*; #(
  parameter int TASK_SLOTS = 64
) (
  input  logic             clk,
  input  dep_ctrl_t        ctrl,
  input  entry_t           res_writer,
  input  entry_t           res_reader,
  input  logic             res_wr_hit,
  input  logic             res_rd_hit,
  input  entry_t           fd_writer,
  input  entry_t           fd_reader,
  input  logic             fd_wr_hit,
  input  logic             fd_rd_hit,
  output logic [DEP_W-1:0] deps
);

  // A task never waits for itself, nor for an entry that holds no slot.
  function automatic logic [DEP_W-1:0] slot_bit(entry_t e, logic [SLOT_W-1:0] own);
    if (!e.valid || e.slot == own || 32'(e.slot) >= TASK_SLOTS) begin
      return '0;
    end
    return DEP_W'(1) << e.slot;
  endfunction

  // A write waits for the last writer and last reader. A read on its own waits
  // for the last writer; after a write by this task that writer is the task.
  function automatic logic [DEP_W-1:0] entry_deps(entry_t w, entry_t r, logic wh,
                                                  logic rh, logic [SLOT_W-1:0] own);
    if (wh) begin
      return slot_bit(w, own) | slot_bit(r, own);
    end
    if (rh) begin
      return slot_bit(w, own);
    end
    return '0;
  endfunction

  logic [DEP_W-1:0] contrib;

  always_comb begin
    contrib = entry_deps(res_writer, res_reader, res_wr_hit, res_rd_hit, ctrl.own_slot)
            | entry_deps(fd_writer, fd_reader, fd_wr_hit, fd_rd_hit, ctrl.own_slot);
  end

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      deps <= '0;
    end else if (ctrl.en) begin
      deps <= deps | contrib;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/read_write_hazard_tracker.sv =====
//------------------------------------------------------------------------------
// read_write_hazard_tracker
// Ordered task scoreboard giving each task its slot and its dependency bitmap.
//------------------------------------------------------------------------------
// Tasks are taken one at a time, in order. A task with work walks the resource
// and frame-data tables together, one entry per cycle, and holds the input while
// it is accepted, while it walks min(RESOURCES, 32) entries, and until its word
// goes to the output register; a skipped task is done once accepted, and a
// task refused for slot overflow skips the walk. The output register lets the
// next task be accepted while the previous result still waits to be taken. A
// frame start clears the tables and the slot counter within the accepting cycle.
`default_nettype none

module read_write_hazard_tracker import rwht_pkg::*; #(
  parameter int RESOURCES  = 32,
  parameter int TASK_SLOTS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              frame_start,
  input  logic              has_work,
  input  logic [MASK_W-1:0] resource_read_mask,
  input  logic [MASK_W-1:0] resource_write_mask,
  input  logic [MASK_W-1:0] framedata_read_mask,
  input  logic [MASK_W-1:0] framedata_write_mask,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SLOT_W-1:0] task_slot,
  output logic [DEP_W-1:0]  depends_on,
  output logic              slot_overflow
);

  localparam int ENTRIES = (RESOURCES < MASK_W) ? RESOURCES : MASK_W;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(TASK_SLOTS + 1);

  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   next_slot;
  logic [CNT_W-1:0]   cur_slot;
  logic               at_limit;
  logic               accept;
  logic               out_free;
  logic               out_load;
  logic               scan_last;
  logic [IDX_W-1:0]   cnt;
  logic [MASK_W-1:0]  res_rd;
  logic [MASK_W-1:0]  res_wr;
  logic [MASK_W-1:0]  fd_rd;
  logic [MASK_W-1:0]  fd_wr;
  logic [SLOT_W-1:0]  slot;
  logic               ovf;
  tbl_ctrl_t          res_ctrl;
  tbl_ctrl_t          fd_ctrl;
  dep_ctrl_t          dep_ctrl;
  entry_t             res_writer;
  entry_t             res_reader;
  entry_t             fd_writer;
  entry_t             fd_reader;
  logic [DEP_W-1:0]   deps;

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cur_slot  = frame_start ? '0 : next_slot;
  assign at_limit  = (cur_slot >= CNT_W'(TASK_SLOTS));
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = (state == ST_DONE) && out_free;
  assign scan_last = (cnt == IDX_W'(ENTRIES - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && has_work) begin
          state_next = at_limit ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    res_ctrl.clear   = accept && frame_start;
    res_ctrl.upd     = (state == ST_SCAN);
    res_ctrl.wr_hit  = res_wr[0];
    res_ctrl.rd_hit  = res_rd[0];
    res_ctrl.slot    = slot;
    fd_ctrl.clear    = accept && frame_start;
    fd_ctrl.upd      = (state == ST_SCAN);
    fd_ctrl.wr_hit   = fd_wr[0];
    fd_ctrl.rd_hit   = fd_rd[0];
    fd_ctrl.slot     = slot;
    dep_ctrl.clr     = accept;
    dep_ctrl.en      = (state == ST_SCAN);
    dep_ctrl.own_slot = slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      next_slot <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        next_slot <= at_limit ? cur_slot : cur_slot + CNT_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Masks shift down so that bit 0 always belongs to the entry being walked.
  always_ff @(posedge clk) begin
    if (accept) begin
      slot   <= at_limit ? '0 : SLOT_W'(cur_slot);
      ovf    <= at_limit;
      cnt    <= '0;
      res_rd <= resource_read_mask;
      res_wr <= resource_write_mask;
      fd_rd  <= framedata_read_mask;
      fd_wr  <= framedata_write_mask;
    end else if (state == ST_SCAN) begin
      cnt    <= cnt + IDX_W'(1);
      res_rd <= res_rd >> 1;
      res_wr <= res_wr >> 1;
      fd_rd  <= fd_rd >> 1;
      fd_wr  <= fd_wr >> 1;
    end
    if (out_load) begin
      task_slot     <= slot;
      depends_on    <= deps;
      slot_overflow <= ovf;
    end
  end

  rwht_table #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_res_table (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (res_ctrl),
    .idx    (cnt),
    .writer (res_writer),
    .reader (res_reader)
  );

  rwht_table #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_fd_table (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (fd_ctrl),
    .idx    (cnt),
    .writer (fd_writer),
    .reader (fd_reader)
  );

  rwht_dep_unit #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_dep_unit (
    .clk        (clk),
    .ctrl       (dep_ctrl),
    .res_writer (res_writer),
    .res_reader (res_reader),
    .res_wr_hit (res_wr[0]),
    .res_rd_hit (res_rd[0]),
    .fd_writer  (fd_writer),
    .fd_reader  (fd_reader),
    .fd_wr_hit  (fd_wr[0]),
    .fd_rd_hit  (fd_rd[0]),
    .deps       (deps)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/rwht_checker.sv =====
//------------------------------------------------------------------------------
// rwht_checker
// Port-level checks for the hazard tracker, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none

module rwht_checker import rwht_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              has_work,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [SLOT_W-1:0] task_slot,
  input wire logic [DEP_W-1:0]  depends_on,
  input wire logic              slot_overflow
);

  // Taking a task with work always leaves the block busy.
  a_busy_after_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && has_work |=> in_stall)
    else $error("input taken again straight after a task with work");

  // A waiting result word holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(depends_on) && $stable(task_slot)
                               && $stable(slot_overflow))
    else $error("result word changed while stalled");

  // An overflowed task carries neither a slot nor dependencies.
  a_overflow_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && slot_overflow |-> depends_on == '0 && task_slot == '0)
    else $error("overflow result carries a slot or dependencies");

  // A task never depends on its own slot.
  a_no_self_dep: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !depends_on[task_slot])
    else $error("task depends on its own slot");

endmodule

bind read_write_hazard_tracker rwht_checker u_rwht_checker (.*);

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// testbench
// Self-checking bench for the read/write hazard tracker.
//------------------------------------------------------------------------------
// Task words are queued by the stimulus process and offered by a driver at the
// falling edge. A monitor at the rising edge predicts each accepted word and
// keeps the expected grants in order. It then checks every result against the
// oldest of them. The run steps through several idling mixes, holds the result
// side off for a long stretch, and relies on a watchdog to catch a hang.
//------------------------------------------------------------------------------

module testbench;
  import rwht_pkg::*;

  localparam int RESOURCES   = 32;
  localparam int TASK_SLOTS  = 64;
  localparam int WATCHDOG    = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 60;
  localparam int RAND_ITEMS  = 300;

  localparam int TBL_RES = 0;
  localparam int TBL_FD  = 1;

  typedef struct {
    bit                frame_start;
    bit                has_work;
    logic [MASK_W-1:0] res_rd;
    logic [MASK_W-1:0] res_wr;
    logic [MASK_W-1:0] fd_rd;
    logic [MASK_W-1:0] fd_wr;
  } task_word_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [DEP_W-1:0]  deps;
    logic              overflow;
  } grant_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              frame_start = 1'b0;
  logic              has_work = 1'b0;
  logic [MASK_W-1:0] resource_read_mask = '0;
  logic [MASK_W-1:0] resource_write_mask = '0;
  logic [MASK_W-1:0] framedata_read_mask = '0;
  logic [MASK_W-1:0] framedata_write_mask = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [SLOT_W-1:0] task_slot;
  logic [DEP_W-1:0]  depends_on;
  logic              slot_overflow;

  read_write_hazard_tracker #(
    .RESOURCES  (RESOURCES),
    .TASK_SLOTS (TASK_SLOTS)
  ) dut (
    .clk                  (clk),
    .rst                  (rst),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .frame_start          (frame_start),
    .has_work             (has_work),
    .resource_read_mask   (resource_read_mask),
    .resource_write_mask  (resource_write_mask),
    .framedata_read_mask  (framedata_read_mask),
    .framedata_write_mask (framedata_write_mask),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .task_slot            (task_slot),
    .depends_on           (depends_on),
    .slot_overflow        (slot_overflow)
  );

  task_word_t pending_tasks[$];
  grant_t     expected_grants[$];
  task_word_t next_word;

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  bit hold_request    = 1'b0;
  bit hold_long       = 1'b0;
  bit in_took         = 1'b0;
  int mismatches      = 0;
  int quiet_cycles    = 0;

  // Scoreboard copy of the tracker state: last writer and last reader per
  // entry for both tables, and the next slot of the frame.
  entry_t     last_writer[2][RESOURCES];
  entry_t     last_reader[2][RESOURCES];
  logic [6:0] slot_counter;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void clear_tables();
    for (int t = 0; t < 2; t++) begin
      for (int c = 0; c < RESOURCES; c++) begin
        last_writer[t][c] = '0;
        last_reader[t][c] = '0;
      end
    end
    slot_counter = '0;
  endfunction

  // A task never waits on itself, so an entry naming its own slot adds nothing.
  function automatic logic [DEP_W-1:0] slot_bit(entry_t e, logic [SLOT_W-1:0] self);
    if (!e.valid || e.slot == self) return '0;
    return 64'd1 << e.slot;
  endfunction

  function automatic bit schedule_task(input task_word_t w, output grant_t g);
    logic [MASK_W-1:0] rmask[2];
    logic [MASK_W-1:0] wmask[2];
    logic [SLOT_W-1:0] self;
    entry_t            mine;
    logic [DEP_W-1:0]  deps;

    g = '0;
    if (w.frame_start) clear_tables();
    if (slot_counter >= TASK_SLOTS) begin
      slot_counter = 7'(TASK_SLOTS);
      if (!w.has_work) return 1'b0;
      g.overflow = 1'b1;
      return 1'b1;
    end
    self = slot_counter[SLOT_W-1:0];
    slot_counter = slot_counter + 7'd1;
    if (!w.has_work) return 1'b0;

    rmask[TBL_RES] = w.res_rd;
    wmask[TBL_RES] = w.res_wr;
    rmask[TBL_FD]  = w.fd_rd;
    wmask[TBL_FD]  = w.fd_wr;
    mine.valid = 1'b1;
    mine.slot  = self;
    deps = '0;
    for (int t = 0; t < 2; t++) begin
      // Writes first: a write leaves the last reader in place.
      for (int c = 0; c < RESOURCES; c++) begin
        if (wmask[t][c]) begin
          deps |= slot_bit(last_writer[t][c], self);
          deps |= slot_bit(last_reader[t][c], self);
          last_writer[t][c] = mine;
        end
      end
      for (int c = 0; c < RESOURCES; c++) begin
        if (rmask[t][c]) begin
          last_reader[t][c] = mine;
          deps |= slot_bit(last_writer[t][c], self);
        end
      end
    end
    g.slot = self;
    g.deps = deps;
    return 1'b1;
  endfunction

  function automatic task_word_t make_task(bit fs, bit hw, logic [MASK_W-1:0] rr,
                                           logic [MASK_W-1:0] rw, logic [MASK_W-1:0] fr,
                                           logic [MASK_W-1:0] fw);
    task_word_t w;
    w.frame_start = fs;
    w.has_work    = hw;
    w.res_rd      = rr;
    w.res_wr      = rw;
    w.fd_rd       = fr;
    w.fd_wr       = fw;
    return w;
  endfunction

  // Mostly a few bits from a narrow window, so that tasks collide often.
  function automatic logic [MASK_W-1:0] pick_mask();
    logic [MASK_W-1:0] m;
    m = '0;
    case ($urandom_range(0, 9))
      0: m = '0;
      1: m = '1;
      2: m = $urandom;
      3: repeat ($urandom_range(1, 4)) m[$urandom_range(0, MASK_W-1)] = 1'b1;
      default: repeat ($urandom_range(1, 3)) m[$urandom_range(0, 7)] = 1'b1;
    endcase
    return m;
  endfunction

  function automatic logic [MASK_W-1:0] pick_write_mask();
    if ($urandom_range(0, 2) == 0) return '0;
    return pick_mask();
  endfunction

  task automatic queue_random_frames(int count);
    int n;
    int frame_len;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 6) == 0) frame_len = $urandom_range(60, 80);
      else frame_len = $urandom_range(1, 24);
      for (int i = 0; i < frame_len; i++) begin
        pending_tasks.push_back(make_task(i == 0, $urandom_range(0, 6) != 0, pick_mask(),
                                          pick_write_mask(), pick_mask(),
                                          pick_write_mask()));
      end
      n += frame_len;
    end
  endtask

  // Sender pause: nothing more is offered until every expected grant is back.
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_tasks.size() != 0 || in_valid || expected_grants.size() != 0);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, bit long_hold);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    queue_random_frames(RAND_ITEMS);
    if (long_hold) hold_request = 1'b1;
    wait_drained();
  endtask

  // Long hold-off on the result side, counted here so the driver keeps going.
  initial begin : receiver_hold
    @(posedge hold_request);
    hold_long = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_long = 1'b0;
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    #1;

    // Directed words: extremes, self dependency, skipped task, write after read.
    pending_tasks.push_back(make_task(1, 1, '0, '0, '0, '0));
    pending_tasks.push_back(make_task(0, 1, '1, '1, '0, '1));
    pending_tasks.push_back(make_task(0, 1, 32'h0000_0001, '0, '0, '0));
    pending_tasks.push_back(make_task(0, 1, '0, 32'h0000_0001, '0, '0));
    pending_tasks.push_back(make_task(0, 1, 32'h0000_0001, '0, '0, '0));
    pending_tasks.push_back(make_task(0, 1, 32'h0000_0001, 32'h0000_0001, '0, '0));
    pending_tasks.push_back(make_task(0, 0, '1, '1, '1, '1));
    pending_tasks.push_back(make_task(0, 1, '0, '0, '1, '0));
    pending_tasks.push_back(make_task(0, 1, '0, '0, '0, 32'h8000_0000));
    pending_tasks.push_back(make_task(0, 1, '0, 32'h8000_0000, 32'h8000_0000, '0));
    pending_tasks.push_back(make_task(0, 1, '1, '1, '1, '1));
    // A frame start mid-stream: the tables forget everything above.
    pending_tasks.push_back(make_task(1, 1, '1, '0, '1, '0));
    pending_tasks.push_back(make_task(0, 1, '0, '1, '0, '1));
    // Fill a frame with skipped tasks, take the last slot, then overflow.
    pending_tasks.push_back(make_task(1, 0, '0, '0, '0, '0));
    repeat (62) pending_tasks.push_back(make_task(0, 0, '1, '1, '1, '1));
    pending_tasks.push_back(make_task(0, 1, '1, '1, '1, '1));
    pending_tasks.push_back(make_task(0, 1, '1, '0, '0, '1));
    pending_tasks.push_back(make_task(0, 0, '1, '0, '0, '1));
    pending_tasks.push_back(make_task(0, 1, '0, '0, '0, '0));
    pending_tasks.push_back(make_task(1, 1, 32'h5555_5555, 32'hAAAA_AAAA,
                                      32'hAAAA_AAAA, 32'h5555_5555));
    pending_tasks.push_back(make_task(0, 1, 32'hAAAA_AAAA, 32'h5555_5555,
                                      32'h5555_5555, 32'hAAAA_AAAA));
    wait_drained();

    run_phase(0, 0, 1'b1);
    run_phase(87, 0, 1'b0);
    run_phase(0, 87, 1'b0);
    run_phase(13, 13, 1'b0);

    repeat (DRAIN_WAIT) @(posedge clk);
    #1;
    if (mismatches == 0 && expected_grants.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_tasks.size() != 0 && $urandom_range(1, 100) > sender_idle_pct) begin
        next_word = pending_tasks.pop_front();
        frame_start          <= next_word.frame_start;
        has_work             <= next_word.has_work;
        resource_read_mask   <= next_word.res_rd;
        resource_write_mask  <= next_word.res_wr;
        framedata_read_mask  <= next_word.fd_rd;
        framedata_write_mask <= next_word.fd_wr;
        in_valid             <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= hold_long || ($urandom_range(1, 100) <= recv_stall_pct);
  end

  always @(posedge clk) begin : monitor
    task_word_t seen;
    grant_t     want;
    grant_t     got;

    if (rst) begin
      in_took <= 1'b0;
      clear_tables();
    end else begin
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        seen = make_task(frame_start, has_work, resource_read_mask, resource_write_mask,
                         framedata_read_mask, framedata_write_mask);
        if (schedule_task(seen, want)) expected_grants.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got.slot     = task_slot;
        got.deps     = depends_on;
        got.overflow = slot_overflow;
        if (expected_grants.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected result word: slot %0d deps %h overflow %b",
                     got.slot, got.deps, got.overflow);
          end
          mismatches++;
        end else begin
          want = expected_grants.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("result mismatch: slot %0d/%0d deps %h/%h overflow %b/%b (exp/got)",
                       want.slot, got.slot, want.deps, got.deps, want.overflow,
                       got.overflow);
            end
            mismatches++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

endmodule
